@@ src/fsp_pkg.sv @@
package fsp_pkg;

    localparam int MAX_SEP    = 8;
    localparam int POS_W      = 16;
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 4;
    localparam int SEP_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int SEP_IDX_W  = (MAX_SEP > 1) ? $clog2(MAX_SEP) : 1;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte data_byte;
        logic  byte_valid;
        logic  last_byte;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] field_start;
        logic [FIELD_W-1:0] field_length;
        logic               is_remainder;
        logic               last_field;
        logic               too_long;
    } t_out_item;

    typedef struct packed {
        logic [OUTQ_LVL_W-1:0] level;
        logic                  almost_full;
    } t_q_status;

endpackage

@@ src/fsp_cell.sv @@
module fsp_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_clear,
    input  fsp_pkg::t_byte i_byte,
    input  logic          i_valid,
    input  fsp_pkg::t_byte i_want,
    input  logic          i_unused,
    output fsp_pkg::t_byte o_byte,
    output logic          o_valid,
    output logic          o_hit
);
    import fsp_pkg::*;

    t_byte r_byte;
    logic  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;
    assign o_hit   = i_unused | (r_valid & (r_byte == i_want));

endmodule

@@ src/fsp_out_fifo.sv @@
module fsp_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  logic               i_push1,
    input  fsp_pkg::t_out_item i_item0,
    input  fsp_pkg::t_out_item i_item1,
    input  logic               i_pop,
    output logic               o_valid,
    output fsp_pkg::t_out_item o_item,
    output fsp_pkg::t_q_status o_status
);
    import fsp_pkg::*;

    t_out_item               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wr;
    logic [OUTQ_PTR_W-1:0]   r_rd;
    logic [OUTQ_LVL_W-1:0]   r_level;
    logic [OUTQ_PTR_W-1:0]   n_wr;
    logic [OUTQ_LVL_W-1:0]   n_level;
    logic [OUTQ_PTR_W-1:0]   w_wr1;
    logic [OUTQ_LVL_W-1:0]   w_push_n;

    assign w_wr1    = r_wr + OUTQ_PTR_W'(1);
    assign w_push_n = OUTQ_LVL_W'(i_push0) + OUTQ_LVL_W'(i_push1);

    always_comb begin
        n_wr    = r_wr + OUTQ_PTR_W'(w_push_n);
        n_level = r_level + w_push_n - OUTQ_LVL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_item0;
        end
        if (i_push1) begin
            r_mem[w_wr1] <= i_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_level <= n_level;
            if (i_pop) begin
                r_rd <= r_rd + OUTQ_PTR_W'(1);
            end
        end
    end

    assign o_valid              = (r_level != '0);
    assign o_item               = r_mem[r_rd];
    assign o_status.level       = r_level;
    assign o_status.almost_full = (r_level >= OUTQ_LVL_W'(OUTQ_DEPTH - 1));

endmodule

@@ src/field_splitter_unit.sv @@
// A field caused by a byte is written into the output queue when the byte is accepted and is offered from there.
// Throughput: one byte per cycle while o_in_stall is low; the separator window compare spans the cell row in one step.
// An item that yields two fields can stall input while the four-entry output queue drains.
// Reset: synchronous, active low; clears string state, queue and config to defaults.
module field_splitter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  fsp_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fsp_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fsp_pkg::SEP_W-1:0]     i_cfg_data
);
    import fsp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = CFG_IDX_W'(3);
    localparam logic MODE_WS  = 1'b0;
    localparam logic MODE_SEP = 1'b1;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    function automatic logic [POS_W-1:0] sat_sub(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c != CNT_MAX) ? (c + CNT_W'(1)) : c;
    endfunction

    function automatic logic is_space(input t_byte b);
        return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    endfunction

    logic                 r_mode;
    logic [SEP_W-1:0]     r_sep;
    logic [LEN_W-1:0]     r_sep_len;
    logic [CNT_W-1:0]     r_max;

    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     r_fstart;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_in_word;
    logic                 r_limit;
    logic                 r_ovf;

    logic                 w_accept;
    logic                 w_shift;
    logic                 w_clear;
    logic [LEN_W-1:0]     w_n;
    logic [POS_W-1:0]     w_pos_n;
    logic                 w_ovf_n;
    logic                 w_match;
    logic                 w_in_hit;
    t_byte                w_cell_byte [MAX_SEP];
    logic [MAX_SEP-1:0]   w_cell_valid;
    logic [MAX_SEP-1:0]   w_cell_hit;

    logic [POS_W-1:0]     v_fstart;
    logic                 v_in_word;
    logic [CNT_W-1:0]     v_cnt;
    logic                 v_limit;
    logic                 v_fill_clr;
    logic                 a_v, b_v, c_v;
    logic [POS_W-1:0]     a_start, a_len, b_start, b_len, c_start, c_len;
    logic                 c_rem;
    t_out_item            w_a, w_b, w_c, w_res0, w_res1;
    logic                 w_push0, w_push1;
    logic                 w_pop;
    t_q_status            w_qstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_WS;
            r_sep     <= '0;
            r_sep_len <= LEN_W'(1);
            r_max     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_SEP:     r_sep     <= i_cfg_data;
                CFG_SEP_LEN: r_sep_len <= i_cfg_data[LEN_W-1:0];
                CFG_MAX:     r_max     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_sep_len == '0) begin
            w_n = LEN_W'(1);
        end else if (r_sep_len > LEN_W'(MAX_SEP)) begin
            w_n = LEN_W'(MAX_SEP);
        end else begin
            w_n = r_sep_len;
        end
    end

    assign w_accept = i_in_valid & ~o_in_stall;
    assign w_shift  = w_accept & i_in_data.byte_valid;
    assign w_clear  = w_accept & (v_fill_clr | i_in_data.last_byte);

    for (genvar gi = 0; gi < MAX_SEP; gi++) begin : g_cell
        logic [LEN_W-1:0]     w_idx;
        logic [SEP_IDX_W-1:0] w_sel;
        t_byte                w_prev;
        logic                 w_prev_valid;

        assign w_idx = w_n - LEN_W'(gi) - LEN_W'(2);
        assign w_sel = w_idx[SEP_IDX_W-1:0];
        if (gi == 0) begin : g_head
            assign w_prev       = i_in_data.data_byte;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev       = w_cell_byte[gi-1];
            assign w_prev_valid = w_cell_valid[gi-1];
        end

        fsp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_shift),
            .i_clear  (w_clear),
            .i_byte   (w_prev),
            .i_valid  (w_prev_valid),
            .i_want   (r_sep[8*w_sel +: 8]),
            .i_unused (LEN_W'(gi + 1) >= w_n),
            .o_byte   (w_cell_byte[gi]),
            .o_valid  (w_cell_valid[gi]),
            .o_hit    (w_cell_hit[gi])
        );
    end

    logic [LEN_W-1:0] w_last_idx;
    assign w_last_idx = w_n - LEN_W'(1);
    assign w_in_hit   = (i_in_data.data_byte == r_sep[8*w_last_idx[SEP_IDX_W-1:0] +: 8]);
    assign w_match    = w_in_hit & (&w_cell_hit);

    assign w_ovf_n = r_ovf | (i_in_data.byte_valid & (r_pos == POS_MAX));
    assign w_pos_n = (i_in_data.byte_valid && r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos;

    always_comb begin
        v_fstart   = r_fstart;
        v_in_word  = r_in_word;
        v_cnt      = r_cnt;
        v_limit    = r_limit;
        v_fill_clr = 1'b0;
        a_v = 1'b0; b_v = 1'b0; c_v = 1'b0;
        a_start = r_fstart; a_len = '0;
        b_start = r_fstart; b_len = '0;
        c_start = r_fstart; c_len = '0; c_rem = 1'b0;

        if (i_in_data.byte_valid && !r_limit) begin
            if (r_mode == MODE_WS) begin
                if (is_space(i_in_data.data_byte)) begin
                    if (r_in_word) begin
                        a_v       = 1'b1;
                        a_start   = r_fstart;
                        a_len     = sat_sub(r_pos, r_fstart);
                        v_in_word = 1'b0;
                        v_cnt     = sat_inc(r_cnt);
                        v_limit   = (r_max != '0) && (v_cnt >= r_max);
                        if (v_limit) begin
                            v_fstart = r_pos;
                        end
                    end
                end else if (!r_in_word) begin
                    v_in_word = 1'b1;
                    v_fstart  = r_pos;
                end
            end else if (w_match) begin
                a_v        = 1'b1;
                a_start    = r_fstart;
                a_len      = sat_sub(sat_sub(w_pos_n, POS_W'(w_n)), r_fstart);
                v_fstart   = w_pos_n;
                v_fill_clr = 1'b1;
                v_cnt      = sat_inc(r_cnt);
                v_limit    = (r_max != '0) && (v_cnt >= r_max);
            end
        end

        if (i_in_data.last_byte) begin
            if (r_mode == MODE_WS) begin
                if (!v_limit && v_in_word) begin
                    b_v       = 1'b1;
                    b_start   = v_fstart;
                    b_len     = sat_sub(w_pos_n, v_fstart);
                    v_in_word = 1'b0;
                    v_cnt     = sat_inc(v_cnt);
                    v_limit   = (r_max != '0) && (v_cnt >= r_max);
                    if (v_limit) begin
                        v_fstart = w_pos_n;
                    end
                end
                if (v_limit) begin
                    c_v     = 1'b1;
                    c_start = v_fstart;
                    c_len   = sat_sub(w_pos_n, v_fstart);
                    c_rem   = 1'b1;
                end
            end else begin
                c_v     = 1'b1;
                c_start = v_fstart;
                c_len   = sat_sub(w_pos_n, v_fstart);
                c_rem   = v_limit;
            end
        end
    end

    always_comb begin
        w_a = '{field_start: FIELD_W'(a_start), field_length: FIELD_W'(a_len),
                is_remainder: 1'b0, last_field: 1'b0, too_long: w_ovf_n};
        w_b = '{field_start: FIELD_W'(b_start), field_length: FIELD_W'(b_len),
                is_remainder: 1'b0, last_field: 1'b0, too_long: w_ovf_n};
        w_c = '{field_start: FIELD_W'(c_start), field_length: FIELD_W'(c_len),
                is_remainder: c_rem, last_field: 1'b0, too_long: w_ovf_n};

        w_res0 = a_v ? w_a : (b_v ? w_b : w_c);
        w_res1 = (a_v && b_v) ? w_b : w_c;
        w_push0 = w_accept & (a_v | b_v | c_v);
        w_push1 = w_accept & ((a_v & b_v) | (a_v & c_v) | (b_v & c_v));
        if (w_push1) begin
            w_res1.last_field = i_in_data.last_byte;
        end else begin
            w_res0.last_field = i_in_data.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_fstart  <= '0;
            r_cnt     <= '0;
            r_in_word <= 1'b0;
            r_limit   <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (w_accept) begin
            if (i_in_data.last_byte) begin
                r_pos     <= '0;
                r_fstart  <= '0;
                r_cnt     <= '0;
                r_in_word <= 1'b0;
                r_limit   <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                r_pos     <= w_pos_n;
                r_fstart  <= v_fstart;
                r_cnt     <= v_cnt;
                r_in_word <= v_in_word;
                r_limit   <= v_limit;
                r_ovf     <= w_ovf_n;
            end
        end
    end

    assign w_pop = o_out_valid & ~i_out_stall;

    fsp_out_fifo u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (w_push0),
        .i_push1  (w_push1),
        .i_item0  (w_res0),
        .i_item1  (w_res1),
        .i_pop    (w_pop),
        .o_valid  (o_out_valid),
        .o_item   (o_out_data),
        .o_status (w_qstat)
    );

    assign o_in_stall = w_qstat.almost_full;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.level <= OUTQ_LVL_W'(OUTQ_DEPTH))
        else $error("output queue over capacity");

    a_word_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_word && r_limit))
        else $error("open word after split limit");

    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_pos == POS_MAX))
        else $error("overflow flag without saturated position");

    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fstart <= r_pos)
        else $error("field start beyond position");
`endif

endmodule
